/* design/sfla_pkg.sv */
// ----------------------------------------------------------------------------
// sfla_pkg: shared types and constants of the sorted free-list allocator
// Pool geometry, list end marker, operation and status codes, and the
// request/response structs of the word access unit.
// ----------------------------------------------------------------------------
package sfla_pkg;

  localparam int POOL_BYTES = 4096;
  localparam int ADDR_W     = $clog2(POOL_BYTES);       // byte address
  localparam int PTR_W      = ADDR_W + 1;               // offset or end mark
  localparam int WALK_MAX   = POOL_BYTES / 8;
  localparam int STEP_W     = $clog2(WALK_MAX + 1);
  localparam int TGT_W      = 14;                       // request plus leftover

  localparam logic [PTR_W-1:0] END_MARK  = PTR_W'(POOL_BYTES);
  localparam logic [63:0]      POOL_WORD = 64'(POOL_BYTES);

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [1:0] STATUS_DONE    = 2'd0;
  localparam logic [1:0] STATUS_NO_FIT  = 2'd1;
  localparam logic [1:0] STATUS_IGNORED = 2'd2;

  localparam logic [1:0] MODE_FIRST = 2'd0;
  localparam logic [1:0] MODE_BEST  = 2'd1;
  localparam logic [1:0] MODE_WORST = 2'd2;

  typedef struct packed {
    logic              go;
    logic              wr;
    logic              clr;
    logic [ADDR_W-1:0] base;
    logic [63:0]       wdata;
  } wport_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] rdata;
  } wport_rsp_t;

  // Any stored next value at or past the pool end means end of list.
  function automatic logic [PTR_W-1:0] clamp_ptr(input logic [63:0] v);
    logic [PTR_W-1:0] r;
    if (v >= POOL_WORD) begin
      r = END_MARK;
    end else begin
      r = v[PTR_W-1:0];
    end
    return r;
  endfunction

endpackage

/* design/sorted_free_list_allocator.sv */
// ----------------------------------------------------------------------------
// sorted_free_list_allocator: byte-pool allocator with address-sorted list
// Allocates by first, best or worst fit and frees by sorted insertion. The
// pool is a byte RAM; every header word goes through one word access unit.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake              Contents
//  in_      slave      in_tvalid/in_tready    tuser: func; tdata: req_size,
//                                             user_addr
//  out_     master     out_tvalid/out_tready  tdata: status, addr,
//                                             granted_size
//  cfg_     slave      cfg_valid/cfg_ready    fit_mode
//
// Every header word access starts the word unit, moves one byte at a time through
// the pool RAM (with registered read data on a read), and ends on the unit's
// done pulse. An allocate reads two words per visited free block, then needs up
// to six word accesses to split and link; a free reads one word per block passed
// plus up to two writes.
// After reset a clearing pass loads the pool image; no request is taken
// meanwhile, while configuration writes are accepted at any time.
// A finished result sits in an output register, so the next request is taken
// while the result waits; a new result waits until that register is empty.
module sorted_free_list_allocator import sfla_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [12:0] req_size, [24:13] user_addr
  input  logic        in_tuser,   // [0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [1:0] status, [13:2] addr, [26:14] granted_size
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data
);

  typedef enum logic [18:0] {
    ST_CLR    = 19'h00001,
    ST_IDLE   = 19'h00002,
    ST_A_CHK  = 19'h00004,
    ST_A_RSZ  = 19'h00008,
    ST_A_RNX  = 19'h00010,
    ST_A_EVAL = 19'h00020,
    ST_A_END  = 19'h00040,
    ST_A_MSZ  = 19'h00080,
    ST_A_MNX  = 19'h00100,
    ST_A_WLS  = 19'h00200,
    ST_A_WLN  = 19'h00400,
    ST_A_LINK = 19'h00800,
    ST_A_WHD  = 19'h01000,
    ST_F_HEAD = 19'h02000,
    ST_F_CHK  = 19'h04000,
    ST_F_RNX  = 19'h08000,
    ST_F_WB   = 19'h10000,
    ST_F_WC   = 19'h20000,
    ST_FIN    = 19'h40000
  } state_t;

  state_t state_r, state_nxt;

  logic [1:0]        fit_mode_r, fit_mode_nxt;
  logic [PTR_W-1:0]  free_head_r, free_head_nxt;
  logic              pend_r, pend_nxt;
  logic [1:0]        mode_r, mode_nxt;
  logic [TGT_W-1:0]  target_r, target_nxt;
  logic [PTR_W-1:0]  cur_r, cur_nxt;
  logic [PTR_W-1:0]  nx_r, nx_nxt;
  logic [ADDR_W-1:0] prev_r, prev_nxt;
  logic              has_prev_r, has_prev_nxt;
  logic              found_r, found_nxt;
  logic [ADDR_W-1:0] tgt_r, tgt_nxt;
  logic [ADDR_W-1:0] tprev_r, tprev_nxt;
  logic              tprev_ok_r, tprev_ok_nxt;
  logic [PTR_W-1:0]  tnext_r, tnext_nxt;
  logic [63:0]       tsize_r, tsize_nxt;
  logic [63:0]       sz_r, sz_nxt;
  logic [STEP_W-1:0] steps_r, steps_nxt;
  logic [TGT_W-1:0]  lo_r, lo_nxt;
  logic [63:0]       lsize_r, lsize_nxt;
  logic [PTR_W-1:0]  lnext_r, lnext_nxt;
  logic [PTR_W-1:0]  link_r, link_nxt;
  logic [ADDR_W-1:0] blk_r, blk_nxt;
  logic [1:0]        res_status_r, res_status_nxt;
  logic [ADDR_W-1:0] res_addr_r, res_addr_nxt;
  logic [12:0]       res_gsize_r, res_gsize_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [31:0]       out_data_r, out_data_nxt;

  wport_req_t wreq;
  wport_rsp_t wrsp;

  logic              in_acc;
  logic [12:0]       in_req_size;
  logic [ADDR_W-1:0] in_user_addr;
  logic [PTR_W-1:0]  head_clamped;
  logic              fits;
  logic              takes;
  logic [63:0]       left;
  logic [TGT_W-1:0]  lo_calc;
  logic [PTR_W-1:0]  rd_nx;

  sfla_wport u_wport (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (wreq),
    .rsp   (wrsp)
  );

  assign in_req_size  = in_tdata[12:0];
  assign in_user_addr = in_tdata[24:13];
  assign in_tready    = (state_r == ST_IDLE);
  assign in_acc       = in_tvalid & in_tready;
  assign cfg_ready    = 1'b1;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;

  assign head_clamped = (free_head_r >= END_MARK) ? END_MARK : free_head_r;
  assign rd_nx        = clamp_ptr(wrsp.rdata);

  // A block fits when its payload after the header covers the target.
  assign fits  = (sz_r >= 64'd8) && ((sz_r - 64'd8) >= 64'(target_r));
  assign takes = fits && ((mode_r == MODE_FIRST) || !found_r ||
                          ((mode_r == MODE_BEST) && (sz_r < tsize_r)) ||
                          ((mode_r == MODE_WORST) && (sz_r > tsize_r)));
  assign left    = tsize_r - 64'd8 - 64'(target_r);
  assign lo_calc = TGT_W'(tgt_r) + TGT_W'(8) + target_r;

  always_comb begin
    state_nxt      = state_r;
    fit_mode_nxt   = fit_mode_r;
    free_head_nxt  = free_head_r;
    pend_nxt       = pend_r;
    mode_nxt       = mode_r;
    target_nxt     = target_r;
    cur_nxt        = cur_r;
    nx_nxt         = nx_r;
    prev_nxt       = prev_r;
    has_prev_nxt   = has_prev_r;
    found_nxt      = found_r;
    tgt_nxt        = tgt_r;
    tprev_nxt      = tprev_r;
    tprev_ok_nxt   = tprev_ok_r;
    tnext_nxt      = tnext_r;
    tsize_nxt      = tsize_r;
    sz_nxt         = sz_r;
    steps_nxt      = steps_r;
    lo_nxt         = lo_r;
    lsize_nxt      = lsize_r;
    lnext_nxt      = lnext_r;
    link_nxt       = link_r;
    blk_nxt        = blk_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    res_gsize_nxt  = res_gsize_r;
    out_valid_nxt  = out_valid_r & ~out_tready;
    out_data_nxt   = out_data_r;
    wreq           = '0;

    if (cfg_valid && cfg_ready) begin
      fit_mode_nxt = cfg_data;
    end

    // Word accesses: issue once, then wait for the unit's done pulse.
    wreq.go = !pend_r && (state_r != ST_IDLE) && (state_r != ST_FIN) &&
              (state_r != ST_A_CHK) && (state_r != ST_A_EVAL) &&
              (state_r != ST_A_END) && (state_r != ST_F_CHK) &&
              !((state_r == ST_A_LINK) && !tprev_ok_r);
    if (wreq.go) begin
      pend_nxt = 1'b1;
    end else if (pend_r && wrsp.done) begin
      pend_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLR: begin
        wreq.clr = 1'b1;
        if (pend_r && wrsp.done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          steps_nxt    = '0;
          cur_nxt      = head_clamped;
          has_prev_nxt = 1'b0;
          found_nxt    = 1'b0;
          prev_nxt     = '0;
          mode_nxt     = (fit_mode_r == 2'd3) ? MODE_FIRST : fit_mode_r;
          target_nxt   = (in_req_size < 13'd8) ? TGT_W'(8) : TGT_W'(in_req_size);
          blk_nxt      = in_user_addr - ADDR_W'(8);
          res_addr_nxt   = '0;
          res_gsize_nxt  = '0;
          res_status_nxt = STATUS_DONE;
          if (in_tuser == FUNC_ALLOC) begin
            state_nxt = ST_A_CHK;
          end else if ((in_user_addr < ADDR_W'(8)) ||
                       ((PTR_W'(in_user_addr) + PTR_W'(8)) > END_MARK)) begin
            res_status_nxt = STATUS_IGNORED;
            state_nxt      = ST_FIN;
          end else if ((head_clamped == END_MARK) ||
                       (head_clamped > PTR_W'(in_user_addr - ADDR_W'(8)))) begin
            state_nxt = ST_F_HEAD;
          end else begin
            state_nxt = ST_F_CHK;
          end
        end
      end
      ST_A_CHK: begin
        if ((cur_r == END_MARK) || (steps_r == STEP_W'(WALK_MAX))) begin
          state_nxt = ST_A_END;
        end else begin
          state_nxt = ST_A_RSZ;
        end
      end
      ST_A_RSZ: begin
        wreq.base = cur_r[ADDR_W-1:0];
        if (pend_r && wrsp.done) begin
          sz_nxt    = wrsp.rdata;
          state_nxt = ST_A_RNX;
        end
      end
      ST_A_RNX: begin
        wreq.base = cur_r[ADDR_W-1:0] + ADDR_W'(8);
        if (pend_r && wrsp.done) begin
          nx_nxt    = rd_nx;
          state_nxt = ST_A_EVAL;
        end
      end
      ST_A_EVAL: begin
        steps_nxt = steps_r + 1'b1;
        if (takes) begin
          found_nxt    = 1'b1;
          tgt_nxt      = cur_r[ADDR_W-1:0];
          tsize_nxt    = sz_r;
          tnext_nxt    = nx_r;
          tprev_nxt    = prev_r;
          tprev_ok_nxt = has_prev_r;
        end
        if (fits && (mode_r == MODE_FIRST)) begin
          state_nxt = ST_A_END;
        end else begin
          prev_nxt     = cur_r[ADDR_W-1:0];
          has_prev_nxt = 1'b1;
          cur_nxt      = nx_r;
          state_nxt    = ST_A_CHK;
        end
      end
      ST_A_END: begin
        if (!found_r) begin
          res_status_nxt = STATUS_NO_FIT;
          state_nxt      = ST_FIN;
        end else if (left <= 64'd16) begin
          // Small leftover goes to the caller.
          target_nxt = target_r + left[TGT_W-1:0];
          link_nxt   = tnext_r;
          state_nxt  = ST_A_LINK;
        end else begin
          lo_nxt    = lo_calc;
          lsize_nxt = left;
          lnext_nxt = tnext_r;
          link_nxt  = PTR_W'(lo_calc[ADDR_W-1:0]);
          if ((tnext_r != END_MARK) && ((64'(tgt_r) + tsize_r) == 64'(tnext_r))) begin
            state_nxt = ST_A_MSZ;
          end else begin
            state_nxt = ST_A_WLS;
          end
        end
      end
      ST_A_MSZ: begin
        wreq.base = tnext_r[ADDR_W-1:0];
        if (pend_r && wrsp.done) begin
          lsize_nxt = lsize_r + wrsp.rdata;
          state_nxt = ST_A_MNX;
        end
      end
      ST_A_MNX: begin
        wreq.base = tnext_r[ADDR_W-1:0] + ADDR_W'(8);
        if (pend_r && wrsp.done) begin
          lnext_nxt = rd_nx;
          state_nxt = ST_A_WLS;
        end
      end
      ST_A_WLS: begin
        wreq.wr    = 1'b1;
        wreq.base  = lo_r[ADDR_W-1:0];
        wreq.wdata = lsize_r;
        if (pend_r && wrsp.done) begin
          state_nxt = ST_A_WLN;
        end
      end
      ST_A_WLN: begin
        wreq.wr    = 1'b1;
        wreq.base  = lo_r[ADDR_W-1:0] + ADDR_W'(8);
        wreq.wdata = 64'(lnext_r);
        if (pend_r && wrsp.done) begin
          state_nxt = ST_A_LINK;
        end
      end
      ST_A_LINK: begin
        if (!tprev_ok_r) begin
          free_head_nxt = link_r;
          state_nxt     = ST_A_WHD;
        end else begin
          wreq.wr    = 1'b1;
          wreq.base  = tprev_r + ADDR_W'(8);
          wreq.wdata = 64'(link_r);
          if (pend_r && wrsp.done) begin
            state_nxt = ST_A_WHD;
          end
        end
      end
      ST_A_WHD: begin
        wreq.wr    = 1'b1;
        wreq.base  = tgt_r;
        wreq.wdata = 64'(target_r) + 64'd8;
        if (pend_r && wrsp.done) begin
          res_status_nxt = STATUS_DONE;
          res_addr_nxt   = tgt_r + ADDR_W'(8);
          res_gsize_nxt  = target_r[12:0];
          state_nxt      = ST_FIN;
        end
      end
      ST_F_HEAD: begin
        // New head: link the current head (or end mark) behind the block.
        wreq.wr    = 1'b1;
        wreq.base  = blk_r + ADDR_W'(8);
        wreq.wdata = 64'(cur_r);
        if (pend_r && wrsp.done) begin
          free_head_nxt = PTR_W'(blk_r);
          state_nxt     = ST_FIN;
        end
      end
      ST_F_CHK: begin
        if ((cur_r == END_MARK) || (steps_r == STEP_W'(WALK_MAX))) begin
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_F_RNX;
        end
      end
      ST_F_RNX: begin
        wreq.base = cur_r[ADDR_W-1:0] + ADDR_W'(8);
        if (pend_r && wrsp.done) begin
          steps_nxt = steps_r + 1'b1;
          if ((rd_nx == END_MARK) || (rd_nx > PTR_W'(blk_r))) begin
            nx_nxt    = rd_nx;
            state_nxt = ST_F_WB;
          end else begin
            cur_nxt   = rd_nx;
            state_nxt = ST_F_CHK;
          end
        end
      end
      ST_F_WB: begin
        wreq.wr    = 1'b1;
        wreq.base  = blk_r + ADDR_W'(8);
        wreq.wdata = 64'(nx_r);
        if (pend_r && wrsp.done) begin
          state_nxt = ST_F_WC;
        end
      end
      ST_F_WC: begin
        wreq.wr    = 1'b1;
        wreq.base  = cur_r[ADDR_W-1:0] + ADDR_W'(8);
        wreq.wdata = 64'(blk_r);
        if (pend_r && wrsp.done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {5'd0, res_gsize_r, res_addr_r, res_status_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      fit_mode_r  <= MODE_FIRST;
      free_head_r <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fit_mode_r  <= fit_mode_nxt;
      free_head_r <= free_head_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mode_r       <= mode_nxt;
    target_r     <= target_nxt;
    cur_r        <= cur_nxt;
    nx_r         <= nx_nxt;
    prev_r       <= prev_nxt;
    has_prev_r   <= has_prev_nxt;
    found_r      <= found_nxt;
    tgt_r        <= tgt_nxt;
    tprev_r      <= tprev_nxt;
    tprev_ok_r   <= tprev_ok_nxt;
    tnext_r      <= tnext_nxt;
    tsize_r      <= tsize_nxt;
    sz_r         <= sz_nxt;
    steps_r      <= steps_nxt;
    lo_r         <= lo_nxt;
    lsize_r      <= lsize_nxt;
    lnext_r      <= lnext_nxt;
    link_r       <= link_nxt;
    blk_r        <= blk_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    res_gsize_r  <= res_gsize_nxt;
    out_data_r   <= out_data_nxt;
  end

  // The list head never holds a value past the end mark.
  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    free_head_r <= END_MARK)
    else $error("free list head out of range");

  // The word unit is only started while it is idle.
  a_go_idle: assert property (@(posedge clk) disable iff (!rst_n)
    wreq.go |-> !wrsp.busy)
    else $error("word access started while busy");

  // A request is taken, then the block works on it before taking another.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("second request taken back to back");

  // A failed allocate grants nothing.
  a_nofit_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[1:0] == STATUS_NO_FIT)) |-> (out_tdata[26:2] == '0))
    else $error("no-fit result carries an address or size");

endmodule

/* design/sfla_ram.sv */
// ----------------------------------------------------------------------------
// sfla_ram: generic single-port RAM
// One write or one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module sfla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* design/sfla_wport.sv */
// ----------------------------------------------------------------------------
// sfla_wport: 64-bit word access unit over the byte pool
// Reads or writes one little-endian 8-byte word a byte per cycle, and runs
// the clearing pass that loads the reset image of the pool.
// ----------------------------------------------------------------------------
module sfla_wport import sfla_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  wport_req_t req,
  output wport_rsp_t rsp
);

  logic              busy_r, busy_nxt;
  logic              wr_r, wr_nxt;
  logic              clr_r, clr_nxt;
  logic              done_r, done_nxt;
  logic              rv_r, rv_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic [ADDR_W-1:0] caddr_r, caddr_nxt;
  logic [3:0]        cnt_r, cnt_nxt;
  logic [63:0]       data_r, data_nxt;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [7:0]        ram_wdata;
  logic [7:0]        ram_rdata;
  logic [7:0]        init_byte;

  sfla_ram #(.WIDTH(8), .DEPTH(POOL_BYTES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Reset image: size word at 0 and end-of-list next word at 8.
  always_comb begin
    init_byte = 8'd0;
    if (caddr_r < ADDR_W'(16)) begin
      init_byte = POOL_WORD[8*caddr_r[2:0] +: 8];
    end
  end

  assign ram_we    = busy_r & (wr_r | clr_r);
  assign ram_addr  = clr_r ? caddr_r : base_r + ADDR_W'(cnt_r[2:0]);
  assign ram_wdata = clr_r ? init_byte : data_r[7:0];

  always_comb begin
    busy_nxt  = busy_r;
    wr_nxt    = wr_r;
    clr_nxt   = clr_r;
    base_nxt  = base_r;
    caddr_nxt = caddr_r;
    cnt_nxt   = cnt_r;
    data_nxt  = data_r;
    rv_nxt    = 1'b0;
    done_nxt  = 1'b0;
    if (!busy_r) begin
      if (req.go) begin
        busy_nxt  = 1'b1;
        wr_nxt    = req.wr;
        clr_nxt   = req.clr;
        base_nxt  = req.base;
        caddr_nxt = '0;
        cnt_nxt   = '0;
        data_nxt  = req.wdata;
      end
    end else if (clr_r) begin
      caddr_nxt = caddr_r + 1'b1;
      if (caddr_r == ADDR_W'(POOL_BYTES - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (wr_r) begin
      data_nxt = {8'd0, data_r[63:8]};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == 4'd7) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else begin
      // Read: byte i issued at count i, captured in the next cycle from the registered RAM data.
      if (rv_r) begin
        data_nxt = {ram_rdata, data_r[63:8]};
      end
      if (!cnt_r[3]) begin
        cnt_nxt = cnt_r + 1'b1;
        rv_nxt  = 1'b1;
      end else begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      rv_r   <= 1'b0;
      wr_r   <= 1'b0;
      clr_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      rv_r   <= rv_nxt;
      wr_r   <= wr_nxt;
      clr_r  <= clr_nxt;
    end
    base_r  <= base_nxt;
    caddr_r <= caddr_nxt;
    cnt_r   <= cnt_nxt;
    data_r  <= data_nxt;
  end

  assign rsp.busy  = busy_r;
  assign rsp.done  = done_r;
  assign rsp.rdata = data_r;

endmodule

/* verif/tb_sorted_free_list_allocator.sv */
// ----------------------------------------------------------------------------
// tb_sorted_free_list_allocator: self-checking bench of the pool allocator
// Drives allocate and free requests under first, best and worst fit, keeps
// its own byte image of the pool with an address-sorted free list, and checks
// every response field against that prediction in arrival order.
// ----------------------------------------------------------------------------
module tb_sorted_free_list_allocator;
  import sfla_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HDR_BYTES   = 8;
  localparam int SPLIT_BYTES = 16;
  localparam int STALL_LIMIT = 400000;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] addr;
    logic [12:0] granted;
  } grant_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // [12:0] req_size, [24:13] user_addr
  logic        in_tuser = 1'b0; // [0] func
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // [1:0] status, [13:2] addr, [26:14] granted_size
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_data = '0;

  sorted_free_list_allocator DUT (.*);

  always #10 clk = ~clk;

  // Shadow copy of the allocator state.
  logic [7:0]  pool_img [POOL_BYTES];
  logic [63:0] head_ptr;
  logic [1:0]  mode_reg;

  grant_t      grant_q[$];      // responses still owed by the block
  logic [11:0] live_blocks[$];  // user addresses currently handed out
  int          src_idle_pct = 0;
  int          snk_stall_pct = 0;
  int          n_errors = 0;
  int          n_requests = 0;
  int          n_responses = 0;
  int          n_allocs_ok = 0;
  int          n_no_fit = 0;
  int          n_frees = 0;
  int          idle_cycles = 0;

  function automatic logic [63:0] word_at(input logic [63:0] off);
    logic [63:0] v;
    logic [63:0] base;
    v = '0;
    base = off % POOL_BYTES;
    for (int i = 7; i >= 0; i--) begin
      v = (v << 8) | 64'(pool_img[(base + i) % POOL_BYTES]);
    end
    return v;
  endfunction

  function automatic void put_word(input logic [63:0] off, input logic [63:0] v);
    logic [63:0] base;
    base = off % POOL_BYTES;
    for (int i = 0; i < 8; i++) begin
      pool_img[(base + i) % POOL_BYTES] = v[7:0];
      v = v >> 8;
    end
  endfunction

  // Next pointer of a free block; anything past the pool means end of list.
  function automatic logic [63:0] link_of(input logic [63:0] blk);
    logic [63:0] n;
    n = word_at(blk + 8);
    return (n >= POOL_BYTES) ? 64'(POOL_BYTES) : n;
  endfunction

  function automatic void reset_image();
    for (int i = 0; i < POOL_BYTES; i++) begin
      pool_img[i] = '0;
    end
    put_word(0, POOL_BYTES);
    put_word(8, POOL_BYTES);
    head_ptr = 0;
    mode_reg = MODE_FIRST;
  endfunction

  // Walks the free list under the current policy and carves out the block.
  function automatic grant_t predict_alloc(input logic [12:0] req);
    grant_t      g;
    logic [63:0] want, cur, prev, tgt, tprev, tnext, tsize, sz, nx, left;
    logic [63:0] link, lo, lsize, lnext;
    logic        has_prev, found, tprev_ok;
    logic [1:0]  pol;
    int          steps;
    g = '0;
    want = (req < HDR_BYTES) ? 64'(HDR_BYTES) : 64'(req);
    cur = (head_ptr >= POOL_BYTES) ? 64'(POOL_BYTES) : head_ptr;
    prev = 0; tgt = 0; tprev = 0; tnext = 0; tsize = 0;
    has_prev = 0; found = 0; tprev_ok = 0;
    pol = (mode_reg == 2'd3) ? MODE_FIRST : mode_reg;
    steps = 0;
    while (cur != POOL_BYTES && steps < POOL_BYTES / 8) begin
      sz = word_at(cur);
      nx = link_of(cur);
      steps++;
      if (sz >= HDR_BYTES && sz - HDR_BYTES >= want) begin
        if (pol == MODE_FIRST || !found || (pol == MODE_BEST && sz < tsize) ||
            (pol == MODE_WORST && sz > tsize)) begin
          found = 1; tgt = cur; tsize = sz; tnext = nx;
          tprev = prev; tprev_ok = has_prev;
        end
        if (pol == MODE_FIRST) break;
      end
      prev = cur; has_prev = 1;
      cur = nx;
    end
    if (!found) begin
      g.status = STATUS_NO_FIT;
      return g;
    end
    left = tsize - HDR_BYTES - want;
    if (left <= SPLIT_BYTES) begin
      // A small leftover is handed to the caller instead of split off.
      want = want + left;
      link = tnext;
    end else begin
      lo = tgt + HDR_BYTES + want;
      lsize = left;
      lnext = tnext;
      // The split remainder absorbs a directly following free block.
      if (tnext != POOL_BYTES && tgt + tsize == tnext) begin
        lsize = lsize + word_at(tnext);
        lnext = link_of(tnext);
      end
      put_word(lo, lsize);
      put_word(lo + 8, lnext);
      link = lo % POOL_BYTES;
    end
    if (link >= POOL_BYTES) link = POOL_BYTES;
    if (tprev_ok) put_word(tprev + 8, link);
    else head_ptr = link;
    put_word(tgt, want + HDR_BYTES);
    g.status = STATUS_DONE;
    g.addr = 12'(tgt + HDR_BYTES);
    g.granted = 13'(want);
    return g;
  endfunction

  // Links a block back in by address; no coalescing is done.
  function automatic grant_t predict_free(input logic [11:0] uaddr);
    grant_t      g;
    logic [63:0] blk, cur, nx;
    int          steps;
    g = '0;
    if (uaddr < HDR_BYTES || 64'(uaddr) + HDR_BYTES > POOL_BYTES) begin
      g.status = STATUS_IGNORED;
      return g;
    end
    g.status = STATUS_DONE;
    blk = 64'(uaddr) - HDR_BYTES;
    cur = (head_ptr >= POOL_BYTES) ? 64'(POOL_BYTES) : head_ptr;
    steps = 0;
    if (cur == POOL_BYTES) begin
      head_ptr = blk;
      put_word(blk + 8, POOL_BYTES);
    end else if (cur > blk) begin
      put_word(blk + 8, cur);
      head_ptr = blk;
    end else begin
      while (cur != POOL_BYTES && steps < POOL_BYTES / 8) begin
        nx = link_of(cur);
        steps++;
        if (nx == POOL_BYTES || nx > blk) begin
          put_word(blk + 8, nx);
          put_word(cur + 8, blk);
          break;
        end
        cur = nx;
      end
    end
    return g;
  endfunction

  // Sends one request. Entered and left at a falling edge; tvalid stays high
  // on exit so a back-to-back request never lowers and raises it in one step.
  task automatic send_request(input logic fn, input logic [12:0] req,
                              input logic [11:0] uaddr);
    grant_t g;
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= {7'd0, uaddr, req};
    do @(posedge clk); while (!in_tready);
    if (fn == FUNC_ALLOC) begin
      g = predict_alloc(req);
      if (g.status == STATUS_DONE) begin
        live_blocks.push_back(g.addr);
        n_allocs_ok++;
      end else begin
        n_no_fit++;
      end
    end else begin
      g = predict_free(uaddr);
      n_frees++;
    end
    grant_q.push_back(g);
    n_requests++;
    @(negedge clk);
  endtask

  task automatic alloc_req(input logic [12:0] req);
    send_request(FUNC_ALLOC, req, 12'($urandom));
  endtask

  task automatic free_req(input logic [11:0] uaddr);
    send_request(FUNC_FREE, 13'($urandom), uaddr);
  endtask

  // Frees one handed-out block chosen at random.
  task automatic free_live();
    int k;
    logic [11:0] a;
    k = $urandom_range(live_blocks.size() - 1);
    a = live_blocks[k];
    live_blocks.delete(k);
    free_req(a);
  endtask

  // Waits until all responses are in, then writes the fit policy.
  task automatic set_fit_mode(input logic [1:0] m);
    in_tvalid <= 1'b0;
    while (grant_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    mode_reg = m;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed();
    alloc_req(13'd4096);   // larger than the whole pool: no fit
    alloc_req(13'd4088);   // exactly the whole pool
    free_req(live_blocks.pop_back());
    alloc_req(13'd4075);   // small leftover absorbed into the grant
    free_req(live_blocks.pop_back());
    alloc_req(13'd0);      // raised to the minimum size
    alloc_req(13'd7);
    free_req(12'd0);       // null free
    free_req(12'd5);       // below the first user offset
    free_req(12'd4095);    // runs past the pool end
    free_req(12'd4089);
    // Split remainder merging with an adjacent free block.
    alloc_req(13'd100);
    alloc_req(13'd100);
    free_req(live_blocks.pop_back());
    alloc_req(13'd40);
    alloc_req(13'd8191 & 13'd4096);
    while (live_blocks.size() != 0) free_req(live_blocks.pop_front());
    alloc_req(13'd4096);   // list is fragmented now: still no fit
  endtask

  // Builds holes of different sizes so each policy picks a different one.
  task automatic test_fit_modes();
    logic [11:0] holes[$];
    for (int m = 0; m < 4; m++) begin
      set_fit_mode(2'(m));
      holes.delete();
      for (int i = 0; i < 6; i++) begin
        alloc_req(13'(40 + 24 * ((i * 5) % 6)));
        holes.push_back(live_blocks.pop_back());
        alloc_req(13'd16);  // spacer keeps the holes apart
      end
      foreach (holes[i]) free_req(holes[i]);
      alloc_req(13'd30);
      alloc_req(13'd60);
      while (live_blocks.size() != 0) free_live();
    end
  endtask

  task automatic test_random(input int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (live_blocks.size() > 24) r = r % 40;
      if (r < 2) begin
        case ($urandom_range(2))
          0: free_req(12'd0);
          1: free_req(12'($urandom_range(7)));
          default: free_req(12'($urandom_range(4089, 4095)));
        endcase
      end else if (r < 40 && live_blocks.size() != 0) begin
        free_live();
      end else if (r < 45) begin
        alloc_req(13'($urandom_range(4096)));
      end else begin
        alloc_req(13'($urandom_range(160)));
      end
    end
  endtask

  // Double and foreign frees corrupt the list, so they come last.
  task automatic test_bad_frees();
    if (live_blocks.size() != 0) begin
      free_req(live_blocks[0]);
      free_req(live_blocks[0]);
    end
    for (int i = 0; i < 6; i++) free_req(12'($urandom_range(8, 4088)));
    for (int i = 0; i < 6; i++) alloc_req(13'($urandom_range(64)));
  endtask

  // Receiver back-pressure.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // Response checker: compares each response with the oldest prediction.
  always @(posedge clk) begin
    grant_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status  = out_tdata[1:0];
      got.addr    = out_tdata[13:2];
      got.granted = out_tdata[26:14];
      n_responses++;
      if (grant_q.size() == 0) begin
        $display("%0t: unexpected response status=%0d addr=%0d granted=%0d",
                 $realtime, got.status, got.addr, got.granted);
        n_errors++;
      end else begin
        want = grant_q.pop_front();
        if (got.status !== want.status)
          $display("%0t: status expected %0d actual %0d", $realtime,
                   want.status, got.status);
        if (got.addr !== want.addr)
          $display("%0t: addr expected %0d actual %0d", $realtime,
                   want.addr, got.addr);
        if (got.granted !== want.granted)
          $display("%0t: granted_size expected %0d actual %0d", $realtime,
                   want.granted, got.granted);
        if (got !== want) n_errors++;
      end
    end
  end

  // Watchdog: a long stretch with no handshake on any channel is a hang.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    reset_image();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_fit_modes();

    // Random traffic in four handshake pressure phases, one policy each.
    set_fit_mode(MODE_FIRST);
    test_random(460);
    set_fit_mode(MODE_BEST);
    src_idle_pct = 70;
    test_random(460);
    set_fit_mode(MODE_WORST);
    src_idle_pct = 0;
    snk_stall_pct = 70;
    test_random(460);
    set_fit_mode(2'd3);
    src_idle_pct = 32;
    snk_stall_pct = 32;
    test_random(460);
    test_bad_frees();

    in_tvalid <= 1'b0;
    while (grant_q.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);

    $display("Checked %0d responses to %0d requests: %0d grants, %0d no-fit, %0d frees,",
             n_responses, n_requests, n_allocs_ok, n_no_fit, n_frees);
    $display("across all fit policies and with idle and stall on both sides.");
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
